### sv/cspc_pkg.sv
package cspc_pkg;

    // Coordinate width, signed fixed point (Q16.16)
    localparam int COORD_BITS = 32;
    // Quotient bits per intersection: one division cell per magnitude bit
    localparam int DIV_STEPS = COORD_BITS + 1;
    localparam int PLANES = 6;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   dist_t;
    typedef logic [COORD_BITS:0]   mag_t;
    typedef logic [COORD_BITS:0]   quo_t;
    typedef logic [COORD_BITS+1:0] den_t;

    // x, y, z, w at index 0..3
    typedef logic [3:0][COORD_BITS-1:0] vec_t;

    typedef struct packed {
        coord_t first_x;
        coord_t first_y;
        coord_t first_z;
        coord_t first_w;
        coord_t second_x;
        coord_t second_y;
        coord_t second_z;
        coord_t second_w;
    } line_in_t;

    typedef struct packed {
        logic   visible;
        logic   first_replaced;
        logic   second_replaced;
        coord_t out_first_x;
        coord_t out_first_y;
        coord_t out_first_z;
        coord_t out_first_w;
        coord_t out_second_x;
        coord_t out_second_y;
        coord_t out_second_z;
        coord_t out_second_w;
    } clip_out_t;

    // Line as it travels from plane to plane
    typedef struct packed {
        logic alive;
        logic rep0;
        logic rep1;
        vec_t v0;
        vec_t v1;
    } line_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_FIRST,
        MODE_SECOND
    } mode_t;

    // Partial scaled-delta division state for one coordinate
    typedef struct packed {
        quo_t q;
        den_t r;
        mag_t mag;
        logic neg;
    } div_t;

endpackage

### sv/clip_space_line_clipper.sv
// Throughput: one line per cycle while line_stall is low; six plane cells in a row,
// each a chain of one-bit division cells per coordinate, all advancing together.
// A skid register behind the output register absorbs one beat when the result is stalled.
// Reset clears all valid bits; coordinate registers are not reset.
module clip_space_line_clipper
    import cspc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      line_valid,
    output logic      line_stall,
    input  line_in_t  line,
    output logic      clip_valid,
    input  logic      clip_stall,
    output clip_out_t clip
);

    logic      en;
    logic      skid_valid_reg;
    clip_out_t skid_reg;
    logic      out_valid_reg;
    clip_out_t out_reg;
    logic      pv     [0:PLANES];
    line_t     pl     [0:PLANES];
    clip_out_t result;

    // Freeze the pipeline while the skid register holds a beat
    assign en = ~skid_valid_reg;
    assign line_stall = skid_valid_reg;

    // Enter the line with both endpoints untouched
    always_comb
    begin
        pl[0].alive = 1'b1;
        pl[0].rep0 = 1'b0;
        pl[0].rep1 = 1'b0;
        pl[0].v0 = {line.first_w, line.first_z, line.first_y, line.first_x};
        pl[0].v1 = {line.second_w, line.second_z, line.second_y, line.second_x};
    end
    assign pv[0] = line_valid;

    for (genvar p = 0; p < PLANES; p++)
    begin : g_plane
        cspc_plane #(
            .AXIS (p / 2),
            .POS  ((p % 2) == 0)
        ) u_plane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (pv[p]),
            .in_line   (pl[p]),
            .out_valid (pv[p+1]),
            .out_line  (pl[p+1])
        );
    end

    // Zero everything for a rejected line
    always_comb
    begin
        result = '0;
        if (pl[PLANES].alive)
        begin
            result.visible = 1'b1;
            result.first_replaced = pl[PLANES].rep0;
            result.second_replaced = pl[PLANES].rep1;
            result.out_first_x = pl[PLANES].v0[0];
            result.out_first_y = pl[PLANES].v0[1];
            result.out_first_z = pl[PLANES].v0[2];
            result.out_first_w = pl[PLANES].v0[3];
            result.out_second_x = pl[PLANES].v1[0];
            result.out_second_y = pl[PLANES].v1[1];
            result.out_second_z = pl[PLANES].v1[2];
            result.out_second_w = pl[PLANES].v1[3];
        end
    end

    // Output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !clip_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pv[PLANES];
            end
        end
        else if (en && pv[PLANES])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !clip_stall)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (en && pv[PLANES])
        begin
            skid_reg <= result;
        end
    end

    assign clip_valid = out_valid_reg;
    assign clip = out_reg;

endmodule

### sv/cspc_div_step.sv
module cspc_div_step
    import cspc_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  den_t num,
    input  den_t den,
    input  div_t din,
    output div_t dout
);

    logic [COORD_BITS+3:0] t;
    logic [COORD_BITS+3:0] den1;
    logic [COORD_BITS+3:0] den2;
    logic [COORD_BITS+3:0] r_sel;
    logic [1:0]            k;
    div_t                  dout_reg;
    div_t                  dout_next;

    // Fold one multiplier bit into quotient and remainder
    always_comb
    begin
        den1 = {2'b00, den};
        den2 = {1'b0, den, 1'b0};
        t = {1'b0, din.r, 1'b0} + (din.mag[COORD_BITS] ? {2'b00, num} : '0);
        if (t >= den2)
        begin
            r_sel = t - den2;
            k = 2'd2;
        end
        else if (t >= den1)
        begin
            r_sel = t - den1;
            k = 2'd1;
        end
        else
        begin
            r_sel = t;
            k = 2'd0;
        end
        dout_next.q = {din.q[COORD_BITS-1:0], 1'b0} + {{(COORD_BITS-1){1'b0}}, k};
        dout_next.r = r_sel[COORD_BITS+1:0];
        dout_next.mag = {din.mag[COORD_BITS-1:0], 1'b0};
        dout_next.neg = din.neg;
    end

    // Advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

### sv/cspc_plane.sv
module cspc_plane
    import cspc_pkg::*;
#(
    parameter int AXIS = 0,
    parameter bit POS = 1'b1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  line_t in_line,
    output logic  out_valid,
    output line_t out_line
);

    // Stage 1: plane distances
    logic  s1_valid_reg;
    line_t s1_line_reg;
    dist_t s1_d0_reg;
    dist_t s1_d1_reg;
    dist_t d0_next;
    dist_t d1_next;

    always_comb
    begin
        if (POS)
        begin
            d0_next = {in_line.v0[3][COORD_BITS-1], in_line.v0[3]}
                    - {in_line.v0[AXIS][COORD_BITS-1], in_line.v0[AXIS]};
            d1_next = {in_line.v1[3][COORD_BITS-1], in_line.v1[3]}
                    - {in_line.v1[AXIS][COORD_BITS-1], in_line.v1[AXIS]};
        end
        else
        begin
            d0_next = {in_line.v0[3][COORD_BITS-1], in_line.v0[3]}
                    + {in_line.v0[AXIS][COORD_BITS-1], in_line.v0[AXIS]};
            d1_next = {in_line.v1[3][COORD_BITS-1], in_line.v1[3]}
                    + {in_line.v1[AXIS][COORD_BITS-1], in_line.v1[AXIS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_line_reg <= in_line;
            s1_d0_reg <= d0_next;
            s1_d1_reg <= d1_next;
        end
    end

    // Stage 2: classify endpoints, set up the division
    logic  s2_valid_reg;
    line_t s2_line_reg;
    line_t s2_line_next;
    mode_t s2_mode_reg;
    mode_t s2_mode_next;
    den_t  s2_num_reg;
    den_t  s2_num_next;
    den_t  s2_den_reg;
    den_t  s2_den_next;
    vec_t  s2_a_reg;
    vec_t  s2_a_next;
    div_t  s2_div_reg  [4];
    div_t  s2_div_next [4];
    vec_t  b_sel;
    dist_t d_in;
    dist_t d_out;
    logic  out0;
    logic  out1;
    mag_t  diff [4];

    always_comb
    begin
        out0 = s1_d0_reg[COORD_BITS];
        out1 = s1_d1_reg[COORD_BITS];
        s2_line_next = s1_line_reg;
        s2_line_next.alive = s1_line_reg.alive & ~(out0 & out1);
        if (out0)
        begin
            s2_mode_next = MODE_FIRST;
            s2_a_next = s1_line_reg.v1;
            b_sel = s1_line_reg.v0;
            d_in = s1_d1_reg;
            d_out = s1_d0_reg;
        end
        else if (out1)
        begin
            s2_mode_next = MODE_SECOND;
            s2_a_next = s1_line_reg.v0;
            b_sel = s1_line_reg.v1;
            d_in = s1_d0_reg;
            d_out = s1_d1_reg;
        end
        else
        begin
            s2_mode_next = MODE_NONE;
            s2_a_next = s1_line_reg.v0;
            b_sel = s1_line_reg.v1;
            d_in = s1_d0_reg;
            d_out = s1_d1_reg;
        end
        s2_num_next = {1'b0, d_in};
        s2_den_next = {d_in[COORD_BITS], d_in} - {d_out[COORD_BITS], d_out};
        for (int k = 0; k < 4; k++)
        begin
            diff[k] = {b_sel[k][COORD_BITS-1], b_sel[k]}
                    - {s2_a_next[k][COORD_BITS-1], s2_a_next[k]};
            s2_div_next[k].q = '0;
            s2_div_next[k].r = '0;
            s2_div_next[k].neg = diff[k][COORD_BITS];
            s2_div_next[k].mag = diff[k][COORD_BITS] ? (~diff[k] + 1'b1) : diff[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_line_reg <= s2_line_next;
            s2_mode_reg <= s2_mode_next;
            s2_num_reg <= s2_num_next;
            s2_den_reg <= s2_den_next;
            s2_a_reg <= s2_a_next;
            for (int k = 0; k < 4; k++)
            begin
                s2_div_reg[k] <= s2_div_next[k];
            end
        end
    end

    // Division chain: one cell per quotient bit and coordinate
    logic  st_valid [0:DIV_STEPS];
    line_t st_line  [0:DIV_STEPS];
    mode_t st_mode  [0:DIV_STEPS];
    den_t  st_num   [0:DIV_STEPS];
    den_t  st_den   [0:DIV_STEPS];
    vec_t  st_a     [0:DIV_STEPS];
    div_t  st_div   [0:DIV_STEPS][4];

    assign st_valid[0] = s2_valid_reg;
    assign st_line[0] = s2_line_reg;
    assign st_mode[0] = s2_mode_reg;
    assign st_num[0] = s2_num_reg;
    assign st_den[0] = s2_den_reg;
    assign st_a[0] = s2_a_reg;

    for (genvar k = 0; k < 4; k++)
    begin : g_div_src
        assign st_div[0][k] = s2_div_reg[k];
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic  valid_reg;
        line_t line_reg;
        mode_t mode_reg;
        den_t  num_reg;
        den_t  den_reg;
        vec_t  a_reg;

        for (genvar k = 0; k < 4; k++)
        begin : g_coord
            cspc_div_step u_step (
                .clk  (clk),
                .en   (en),
                .num  (st_num[i]),
                .den  (st_den[i]),
                .din  (st_div[i][k]),
                .dout (st_div[i+1][k])
            );
        end

        // Carry side data along with the division
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= st_valid[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                line_reg <= st_line[i];
                mode_reg <= st_mode[i];
                num_reg <= st_num[i];
                den_reg <= st_den[i];
                a_reg <= st_a[i];
            end
        end

        assign st_valid[i+1] = valid_reg;
        assign st_line[i+1] = line_reg;
        assign st_mode[i+1] = mode_reg;
        assign st_num[i+1] = num_reg;
        assign st_den[i+1] = den_reg;
        assign st_a[i+1] = a_reg;
    end

    // Final stage: round, add to inside endpoint, replace
    logic  fin_valid_reg;
    line_t fin_line_reg;
    line_t fin_line_next;
    vec_t  res;
    quo_t  q_rnd [4];
    mag_t  term  [4];
    mag_t  sum   [4];
    den_t  half;

    always_comb
    begin
        fin_line_next = st_line[DIV_STEPS];
        for (int k = 0; k < 4; k++)
        begin
            half = st_den[DIV_STEPS] - st_div[DIV_STEPS][k].r;
            q_rnd[k] = st_div[DIV_STEPS][k].q
                     + {{COORD_BITS{1'b0}}, (st_div[DIV_STEPS][k].r >= half)};
            term[k] = st_div[DIV_STEPS][k].neg ? (~q_rnd[k] + 1'b1) : q_rnd[k];
            sum[k] = {st_a[DIV_STEPS][k][COORD_BITS-1], st_a[DIV_STEPS][k]} + term[k];
            res[k] = sum[k][COORD_BITS-1:0];
        end
        case (st_mode[DIV_STEPS])
            MODE_FIRST:
            begin
                fin_line_next.v0 = res;
                fin_line_next.rep0 = 1'b1;
            end
            MODE_SECOND:
            begin
                fin_line_next.v1 = res;
                fin_line_next.rep1 = 1'b1;
            end
            default:
            begin
                fin_line_next = st_line[DIV_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= st_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_line_reg <= fin_line_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_line = fin_line_reg;

endmodule
